[rtl/sbb_pkg.sv]
// ----------------------------------------------------------------------------
// sbb_pkg: shared types and constants of the separable binomial blur
// Field widths, register indexes, request codes and the operation record
// passed from the front end to the line-buffer back end.
// ----------------------------------------------------------------------------
package sbb_pkg;

	localparam int SAMPLE_W      = 16;
	localparam int HSUM_W        = 18;
	localparam int BLUR_W        = 20;
	localparam int IN_TDATA_W    = 16;
	localparam int IN_TUSER_W    = 2;
	localparam int OUT_TDATA_W   = 24;

	localparam int CFG_IDX_W     = 1;
	localparam int CFG_DATA_W    = 13;
	localparam int FRAME_W_BITS  = 11;
	localparam int FRAME_H_BITS  = 13;
	localparam int FRAME_W_RESET = 1024;
	localparam int FRAME_H_RESET = 1;

	localparam logic [CFG_IDX_W-1:0] CFG_IDX_FRAME_WIDTH  = 1'd0;
	localparam logic [CFG_IDX_W-1:0] CFG_IDX_FRAME_HEIGHT = 1'd1;

	localparam logic REQ_SAMPLE = 1'b0;
	localparam logic REQ_DRAIN  = 1'b1;

	localparam int QUEUE_DEPTH = 4;
	localparam int QPTR_W      = $clog2(QUEUE_DEPTH);

	// STORE: write a horizontal sum into both line buffers, no output
	// BLEND: read both buffers, emit the vertical sum, shift the column down
	// DRAIN: read both buffers, emit the bottom-clamped vertical sum
	typedef enum logic [1:0] {
		OP_STORE,
		OP_BLEND,
		OP_DRAIN
	} op_kind_t;

	typedef struct packed {
		op_kind_t                   kind;
		logic signed [HSUM_W-1:0]   hsum;
		logic                       last;
	} op_t;

endpackage

[rtl/separable_binomial_blur_3x3.sv]
// ----------------------------------------------------------------------------
// separable_binomial_blur_3x3: 3x3 binomial blur over a raster sample stream
// Horizontal 1-2-1 then vertical 1-2-1 filter, edges clamped, exact result.
// ----------------------------------------------------------------------------
// Feed a frame of frame_width x frame_height samples in raster order, then
// drain beats; each blurred pixel comes out exact at 16 times the input scale
// (8 fraction bits in, 12 out), with flagged samples used as zero. Sample k of
// a frame yields pixel k-W-1 once k reaches W+1; the remaining W+1 pixels (W
// for a single-row frame) come one per drain beat, the last one with tlast
// set. Samples sent before the drain is complete are dropped, and surplus
// drain beats produce nothing. The block takes one beat per clock unless its
// op queue is full: every beat maps to at most one read-modify-write of a
// column of the two line buffers (MAX_WIDTH x 18 bits each, one read and one
// write port per cycle); the only exception is the beat that ends a
// single-row frame, which holds off the input as the tail column needs a
// second line-buffer write. Each beat passes the op queue, the read stage
// and the output register before m_tvalid rises. A register write restarts
// the frame; the line buffers need no clearing after reset.
// ----------------------------------------------------------------------------
module separable_binomial_blur_3x3 #(
	parameter int MAX_WIDTH  = 1024,
	parameter int MAX_HEIGHT = 4096
) (
	input  logic                                  clk,
	input  logic                                  arst_n,
	input  logic                                  s_tvalid,
	output logic                                  s_tready,
	// [15:0] sample
	input  logic [sbb_pkg::IN_TDATA_W-1:0]        s_tdata,
	// [0] req_type, [1] sample_invalid
	input  logic [sbb_pkg::IN_TUSER_W-1:0]        s_tuser,
	output logic                                  m_tvalid,
	input  logic                                  m_tready,
	// [19:0] blurred, [23:20] zero
	output logic [sbb_pkg::OUT_TDATA_W-1:0]       m_tdata,
	// last_of_frame
	output logic                                  m_tlast,
	input  logic                                  cfg_we,
	input  logic [sbb_pkg::CFG_IDX_W-1:0]         cfg_index,
	input  logic [sbb_pkg::CFG_DATA_W-1:0]        cfg_data
);

	localparam int ADDR_W = (MAX_WIDTH > 1) ? $clog2(MAX_WIDTH) : 1;

	logic signed [sbb_pkg::SAMPLE_W-1:0] sample;
	logic                                push, q_full, head_valid, pop;
	sbb_pkg::op_t                        push_op, head_op;
	logic [ADDR_W-1:0]                   push_addr, head_addr;
	logic signed [sbb_pkg::BLUR_W-1:0]   blurred;

	assign sample = s_tdata[sbb_pkg::SAMPLE_W-1:0];

	// classify beats, track position, hand ops to the queue
	sbb_front #(
		.MAX_WIDTH  (MAX_WIDTH),
		.MAX_HEIGHT (MAX_HEIGHT)
	) u_front (
		.clk            (clk),
		.arst_n         (arst_n),
		.in_valid       (s_tvalid),
		.in_ready       (s_tready),
		.req_type       (s_tuser[0]),
		.sample         (sample),
		.sample_invalid (s_tuser[1]),
		.cfg_we         (cfg_we),
		.cfg_index      (cfg_index),
		.cfg_data       (cfg_data),
		.q_full         (q_full),
		.push           (push),
		.push_op        (push_op),
		.push_addr      (push_addr)
	);

	// decouple the front end from output back-pressure
	sbb_queue #(
		.ADDR_W (ADDR_W)
	) u_queue (
		.clk        (clk),
		.arst_n     (arst_n),
		.push       (push),
		.push_op    (push_op),
		.push_addr  (push_addr),
		.pop        (pop),
		.full       (q_full),
		.head_valid (head_valid),
		.head_op    (head_op),
		.head_addr  (head_addr)
	);

	// line buffers, vertical sum and output register
	sbb_back #(
		.MAX_WIDTH (MAX_WIDTH)
	) u_back (
		.clk           (clk),
		.arst_n        (arst_n),
		.op_valid      (head_valid),
		.op            (head_op),
		.op_addr       (head_addr),
		.op_pop        (pop),
		.out_valid     (m_tvalid),
		.out_ready     (m_tready),
		.blurred       (blurred),
		.last_of_frame (m_tlast)
	);

	// pad the result to whole bytes
	assign m_tdata = {{(sbb_pkg::OUT_TDATA_W - sbb_pkg::BLUR_W){1'b0}}, blurred};

endmodule

[rtl/sbb_front.sv]
// ----------------------------------------------------------------------------
// sbb_front: request classification and raster position tracking
// Holds the configuration, the two most recent samples, the column and row
// position and the drain count; turns each request into a line-buffer op.
// ----------------------------------------------------------------------------
module sbb_front #(
	parameter int MAX_WIDTH  = 1024,
	parameter int MAX_HEIGHT = 4096
) (
	input  logic                                  clk,
	input  logic                                  arst_n,
	input  logic                                  in_valid,
	output logic                                  in_ready,
	input  logic                                  req_type,
	input  logic signed [sbb_pkg::SAMPLE_W-1:0]   sample,
	input  logic                                  sample_invalid,
	input  logic                                  cfg_we,
	input  logic [sbb_pkg::CFG_IDX_W-1:0]         cfg_index,
	input  logic [sbb_pkg::CFG_DATA_W-1:0]        cfg_data,
	input  logic                                  q_full,
	output logic                                  push,
	output sbb_pkg::op_t                          push_op,
	output logic [((MAX_WIDTH > 1) ? $clog2(MAX_WIDTH) : 1)-1:0] push_addr
);

	localparam int AW  = (MAX_WIDTH > 1) ? $clog2(MAX_WIDTH) : 1;
	localparam int RW  = (MAX_HEIGHT > 1) ? $clog2(MAX_HEIGHT) : 1;
	localparam int WCW = $clog2(MAX_WIDTH + 2);
	localparam int HCW = $clog2(MAX_HEIGHT + 2);
	localparam int HW  = sbb_pkg::HSUM_W;
	localparam int SW  = sbb_pkg::SAMPLE_W;

	logic signed [SW-1:0] rs0_q, rs1_q, rs0_d, rs1_d;
	logic [AW-1:0]        col_q, col_d;
	logic [RW-1:0]        row_q, row_d;
	logic [WCW-1:0]       pending_q, pending_d;
	logic [WCW-1:0]       eff_w_q, cfg_w;
	logic [HCW-1:0]       eff_h_q, cfg_h;
	logic                 extra_q, extra_d;

	logic signed [SW-1:0] s_val;
	logic signed [HW-1:0] s_ext, rs0_ext, rs1_ext, tail_h, mid_h;
	logic [AW-1:0]        w_last_addr;
	logic                 col_wrap, row_wrap, accept;
	logic [31:0]          w_req, h_req;

	assign in_ready = !q_full && !extra_q;
	assign accept   = in_valid && in_ready;

	assign s_val   = sample_invalid ? '0 : sample;
	assign s_ext   = {{(HW-SW){s_val[SW-1]}}, s_val};
	assign rs0_ext = {{(HW-SW){rs0_q[SW-1]}}, rs0_q};
	assign rs1_ext = {{(HW-SW){rs1_q[SW-1]}}, rs1_q};

	// last column of a row: its right neighbor is clamped onto itself
	assign tail_h = ((eff_w_q >= WCW'(2)) ? rs1_ext : rs0_ext) + rs0_ext + (rs0_ext <<< 1);
	// interior or left column: left neighbor clamps at column zero
	assign mid_h  = ((col_q == AW'(1)) ? rs0_ext : rs1_ext) + (rs0_ext <<< 1) + s_ext;

	assign w_last_addr = AW'(eff_w_q - WCW'(1));
	assign col_wrap    = (WCW'(col_q) + WCW'(1)) == eff_w_q;
	assign row_wrap    = (HCW'(row_q) + HCW'(1)) == eff_h_q;

	always_comb begin
		w_req = 32'(cfg_data[sbb_pkg::FRAME_W_BITS-1:0]);
		h_req = 32'(cfg_data[sbb_pkg::FRAME_H_BITS-1:0]);
		if (w_req == 32'd0) begin
			w_req = 32'd1;
		end else if (w_req > 32'(MAX_WIDTH)) begin
			w_req = 32'(MAX_WIDTH);
		end
		if (h_req == 32'd0) begin
			h_req = 32'd1;
		end else if (h_req > 32'(MAX_HEIGHT)) begin
			h_req = 32'(MAX_HEIGHT);
		end
		cfg_w = WCW'(w_req);
		cfg_h = HCW'(h_req);
	end

	always_comb begin
		push         = 1'b0;
		push_op.kind = sbb_pkg::OP_STORE;
		push_op.hsum = '0;
		push_op.last = 1'b0;
		push_addr    = '0;
		rs0_d        = rs0_q;
		rs1_d        = rs1_q;
		col_d        = col_q;
		row_d        = row_q;
		pending_d    = pending_q;
		extra_d      = extra_q;

		if (extra_q) begin
			// single-row frame: store the tail column of the only row
			if (!q_full) begin
				push         = 1'b1;
				push_op.kind = sbb_pkg::OP_STORE;
				push_op.hsum = tail_h;
				push_addr    = w_last_addr;
				extra_d      = 1'b0;
			end
		end else if (accept) begin
			if (req_type == sbb_pkg::REQ_SAMPLE) begin
				// drop samples while the previous frame still drains
				if (pending_q == '0) begin
					if (col_q != '0) begin
						push         = 1'b1;
						push_op.kind = (row_q == '0) ? sbb_pkg::OP_STORE : sbb_pkg::OP_BLEND;
						push_op.hsum = mid_h;
						push_addr    = col_q - AW'(1);
					end else if (row_q != '0) begin
						push         = 1'b1;
						push_op.kind = (row_q == RW'(1)) ? sbb_pkg::OP_STORE
						                                 : sbb_pkg::OP_BLEND;
						push_op.hsum = tail_h;
						push_addr    = w_last_addr;
					end
					rs1_d = (col_q == '0) ? s_val : rs0_q;
					rs0_d = s_val;
					if (col_wrap) begin
						col_d = '0;
						if (row_wrap) begin
							row_d = '0;
							if (eff_h_q == HCW'(1)) begin
								extra_d   = 1'b1;
								pending_d = eff_w_q;
							end else begin
								pending_d = eff_w_q + WCW'(1);
							end
						end else begin
							row_d = row_q + RW'(1);
						end
					end else begin
						col_d = col_q + AW'(1);
					end
				end
			end else begin
				if (pending_q != '0) begin
					push = 1'b1;
					if (pending_q > eff_w_q) begin
						// finish the last column of the last row
						push_op.kind = sbb_pkg::OP_BLEND;
						push_op.hsum = tail_h;
						push_addr    = w_last_addr;
					end else begin
						push_op.kind = sbb_pkg::OP_DRAIN;
						push_addr    = AW'(eff_w_q - pending_q);
						push_op.last = (pending_q == WCW'(1));
					end
					pending_d = pending_q - WCW'(1);
				end
			end
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			rs0_q     <= '0;
			rs1_q     <= '0;
			col_q     <= '0;
			row_q     <= '0;
			pending_q <= '0;
			extra_q   <= 1'b0;
			eff_w_q   <= WCW'((MAX_WIDTH < sbb_pkg::FRAME_W_RESET) ? MAX_WIDTH
			                                                      : sbb_pkg::FRAME_W_RESET);
			eff_h_q   <= HCW'(sbb_pkg::FRAME_H_RESET);
		end else if (cfg_we) begin
			// a register write restarts the frame
			case (cfg_index)
				sbb_pkg::CFG_IDX_FRAME_WIDTH: begin
					eff_w_q <= cfg_w;
				end
				sbb_pkg::CFG_IDX_FRAME_HEIGHT: begin
					eff_h_q <= cfg_h;
				end
				default: begin
				end
			endcase
			col_q     <= '0;
			row_q     <= '0;
			pending_q <= '0;
			extra_q   <= 1'b0;
		end else begin
			rs0_q     <= rs0_d;
			rs1_q     <= rs1_d;
			col_q     <= col_d;
			row_q     <= row_d;
			pending_q <= pending_d;
			extra_q   <= extra_d;
		end
	end

endmodule

[rtl/sbb_queue.sv]
// ----------------------------------------------------------------------------
// sbb_queue: short op queue between front end and back end
// Small register FIFO that lets either side stall without stalling the other.
// ----------------------------------------------------------------------------
module sbb_queue #(
	parameter int ADDR_W = 10
) (
	input  logic                clk,
	input  logic                arst_n,
	input  logic                push,
	input  sbb_pkg::op_t        push_op,
	input  logic [ADDR_W-1:0]   push_addr,
	input  logic                pop,
	output logic                full,
	output logic                head_valid,
	output sbb_pkg::op_t        head_op,
	output logic [ADDR_W-1:0]   head_addr
);

	localparam int PW = sbb_pkg::QPTR_W;

	sbb_pkg::op_t      op_mem   [sbb_pkg::QUEUE_DEPTH];
	logic [ADDR_W-1:0] addr_mem [sbb_pkg::QUEUE_DEPTH];
	logic [PW-1:0]     wr_ptr_q, rd_ptr_q;
	logic [PW:0]       count_q;
	logic              do_push, do_pop;

	assign full       = count_q == (PW+1)'(sbb_pkg::QUEUE_DEPTH);
	assign head_valid = count_q != '0;
	assign head_op    = op_mem[rd_ptr_q];
	assign head_addr  = addr_mem[rd_ptr_q];
	assign do_push    = push && !full;
	assign do_pop     = pop && head_valid;

	always_ff @(posedge clk) begin
		if (do_push) begin
			op_mem[wr_ptr_q]   <= push_op;
			addr_mem[wr_ptr_q] <= push_addr;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			wr_ptr_q <= '0;
			rd_ptr_q <= '0;
			count_q  <= '0;
		end else begin
			if (do_push) begin
				wr_ptr_q <= wr_ptr_q + PW'(1);
			end
			if (do_pop) begin
				rd_ptr_q <= rd_ptr_q + PW'(1);
			end
			case ({do_push, do_pop})
				2'b10:   count_q <= count_q + (PW+1)'(1);
				2'b01:   count_q <= count_q - (PW+1)'(1);
				default: count_q <= count_q;
			endcase
		end
	end

endmodule

[rtl/sbb_back.sv]
// ----------------------------------------------------------------------------
// sbb_back: line buffers and vertical 1-2-1 sum
// Two single-port-write line buffers hold the horizontal sums of the two rows
// above; each op reads both at one column; blend and store write back.
// ----------------------------------------------------------------------------
module sbb_back #(
	parameter int MAX_WIDTH = 1024
) (
	input  logic                                  clk,
	input  logic                                  arst_n,
	input  logic                                  op_valid,
	input  sbb_pkg::op_t                          op,
	input  logic [((MAX_WIDTH > 1) ? $clog2(MAX_WIDTH) : 1)-1:0] op_addr,
	output logic                                  op_pop,
	output logic                                  out_valid,
	input  logic                                  out_ready,
	output logic signed [sbb_pkg::BLUR_W-1:0]     blurred,
	output logic                                  last_of_frame
);

	localparam int AW = (MAX_WIDTH > 1) ? $clog2(MAX_WIDTH) : 1;
	localparam int HW = sbb_pkg::HSUM_W;
	localparam int BW = sbb_pkg::BLUR_W;

	logic signed [HW-1:0] mem_two   [MAX_WIDTH];
	logic signed [HW-1:0] mem_above [MAX_WIDTH];

	logic                 valid_s1;
	sbb_pkg::op_t         op_s1;
	logic [AW-1:0]        addr_s1;
	logic signed [HW-1:0] rd_two_s1, rd_above_s1;

	logic                 fwd_valid_q;
	logic [AW-1:0]        fwd_addr_q;
	logic signed [HW-1:0] fwd_two_q, fwd_above_q;

	logic                 out_valid_q, out_last_q;
	logic signed [BW-1:0] out_data_q;

	logic                 adv, wr_en, emit, fwd_hit;
	logic signed [HW-1:0] two_e, above_e, wr_two;
	logic signed [BW-1:0] two_x, above_x, h_x, v;

	assign adv    = !out_valid_q || out_ready;
	assign op_pop = adv && op_valid;

	// the previous op wrote this column at the same edge this one read it
	assign fwd_hit = fwd_valid_q && (fwd_addr_q == addr_s1);
	assign two_e   = fwd_hit ? fwd_two_q   : rd_two_s1;
	assign above_e = fwd_hit ? fwd_above_q : rd_above_s1;

	assign wr_en  = adv && valid_s1 && (op_s1.kind != sbb_pkg::OP_DRAIN);
	assign wr_two = (op_s1.kind == sbb_pkg::OP_STORE) ? op_s1.hsum : above_e;
	assign emit   = valid_s1 && (op_s1.kind != sbb_pkg::OP_STORE);

	assign two_x   = {{(BW-HW){two_e[HW-1]}}, two_e};
	assign above_x = {{(BW-HW){above_e[HW-1]}}, above_e};
	assign h_x     = {{(BW-HW){op_s1.hsum[HW-1]}}, op_s1.hsum};

	always_comb begin
		case (op_s1.kind)
			sbb_pkg::OP_BLEND: v = two_x + (above_x <<< 1) + h_x;
			sbb_pkg::OP_DRAIN: v = two_x + above_x + (above_x <<< 1);
			default:           v = '0;
		endcase
	end

	always_ff @(posedge clk) begin
		if (wr_en) begin
			mem_two[addr_s1]   <= wr_two;
			mem_above[addr_s1] <= op_s1.hsum;
		end
		if (op_pop) begin
			rd_two_s1   <= mem_two[op_addr];
			rd_above_s1 <= mem_above[op_addr];
			op_s1       <= op;
			addr_s1     <= op_addr;
		end
		if (adv) begin
			fwd_addr_q  <= addr_s1;
			fwd_two_q   <= wr_two;
			fwd_above_q <= op_s1.hsum;
		end
		if (adv && emit) begin
			out_data_q <= v;
			out_last_q <= op_s1.last;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s1    <= 1'b0;
			fwd_valid_q <= 1'b0;
			out_valid_q <= 1'b0;
		end else if (adv) begin
			valid_s1    <= op_valid;
			fwd_valid_q <= wr_en;
			out_valid_q <= emit;
		end
	end

	assign out_valid     = out_valid_q;
	assign blurred       = out_data_q;
	assign last_of_frame = out_last_q;

endmodule

[verif/tb_top.sv]
// ----------------------------------------------------------------------------
// tb_top: stream-level test of the separable binomial blur
// Drives raster frames and drain beats into the slave side, keeps a scoreboard
// of expected blurred pixels from a behavioral line-buffer model, and checks
// every master-side beat in order while both sides idle and stall at random.
// ----------------------------------------------------------------------------
module tb_top;

	import sbb_pkg::*;

	localparam int LINE_MAX  = 1024;
	localparam int ROWS_MAX  = 4096;
	localparam int CLK_HALF  = 5;
	// Idle cycles before a register write: pipeline depth plus a margin, so
	// beats that produce no pixel have left the block too.
	localparam int SETTLE    = 8;
	localparam int HOLD_LONG = 400;

	typedef struct packed {
		logic signed [BLUR_W-1:0] blurred;
		logic                     last;
	} pixel_t;

	logic                    clk       = 1'b0;
	logic                    arst_n    = 1'b0;
	logic                    s_tvalid  = 1'b0;
	logic                    s_tready;
	logic [IN_TDATA_W-1:0]   s_tdata   = '0;
	logic [IN_TUSER_W-1:0]   s_tuser   = '0;
	logic                    m_tvalid;
	logic                    m_tready  = 1'b0;
	logic [OUT_TDATA_W-1:0]  m_tdata;
	logic                    m_tlast;
	logic                    cfg_we    = 1'b0;
	logic [CFG_IDX_W-1:0]    cfg_index = '0;
	logic [CFG_DATA_W-1:0]   cfg_data  = '0;

	// Scoreboard: pixels the model says the block still owes, oldest first.
	pixel_t      owed_pixels[$];
	int unsigned fails      = 0;
	// Beats that moved the model (samples taken, drains that had work to do).
	int unsigned live_beats = 0;

	// Idle control for both sides; the receiver hold-off is requested by the
	// test and counted down by the receiver process itself.
	bit          tx_gaps    = 1'b1;
	bit          rx_gaps    = 1'b1;
	bit          rx_hold_req = 1'b0;
	int unsigned rx_hold_left = 0;

	// Behavioral copy of the block state.
	logic signed [HSUM_W-1:0]     sums_above     [LINE_MAX];
	logic signed [HSUM_W-1:0]     sums_two_above [LINE_MAX];
	logic signed [SAMPLE_W-1:0]   last_smp       = '0;
	logic signed [SAMPLE_W-1:0]   prev_smp       = '0;
	int unsigned                  col_pos        = 0;
	int unsigned                  row_pos        = 0;
	int unsigned                  drain_owed     = 0;
	logic [FRAME_W_BITS-1:0]      width_reg      = FRAME_W_BITS'(FRAME_W_RESET);
	logic [FRAME_H_BITS-1:0]      height_reg     = FRAME_H_BITS'(FRAME_H_RESET);

	separable_binomial_blur_3x3 #(
		.MAX_WIDTH  (LINE_MAX),
		.MAX_HEIGHT (ROWS_MAX)
	) u_top (
		.clk       (clk),
		.arst_n    (arst_n),
		.s_tvalid  (s_tvalid),
		.s_tready  (s_tready),
		.s_tdata   (s_tdata),
		.s_tuser   (s_tuser),
		.m_tvalid  (m_tvalid),
		.m_tready  (m_tready),
		.m_tdata   (m_tdata),
		.m_tlast   (m_tlast),
		.cfg_we    (cfg_we),
		.cfg_index (cfg_index),
		.cfg_data  (cfg_data)
	);

	initial begin
		forever #CLK_HALF clk = ~clk;
	end

	// ------------------------------------------------------------------------
	// Blur model
	// ------------------------------------------------------------------------

	// Zero sizes act as one, oversize values clamp to the line-buffer limits.
	function automatic int unsigned eff_width();
		if (width_reg == 0)
			return 1;
		if (width_reg > LINE_MAX)
			return LINE_MAX;
		return width_reg;
	endfunction

	function automatic int unsigned eff_height();
		if (height_reg == 0)
			return 1;
		if (height_reg > ROWS_MAX)
			return ROWS_MAX;
		return height_reg;
	endfunction

	// Horizontal sum of the right-hand column: the right neighbor clamps to
	// the edge sample, and for a one-wide row the left one does too.
	function automatic int tail_hsum(int unsigned w);
		int lft;
		lft = (w >= 2) ? int'(prev_smp) : int'(last_smp);
		return lft + 3 * int'(last_smp);
	endfunction

	// Push horizontal sum h of row q into column x. Row 0 fills both line
	// stores, which clamps the top edge; later rows yield the vertical sum
	// centered on row q-1 and shift the column down.
	function automatic bit shift_column(int unsigned x, int unsigned q, int h,
			output int vsum);
		vsum = 0;
		if (q == 0) begin
			sums_two_above[x] = HSUM_W'(h);
			sums_above[x]     = HSUM_W'(h);
			return 1'b0;
		end
		vsum = int'(sums_two_above[x]) + 2 * int'(sums_above[x]) + h;
		sums_two_above[x] = sums_above[x];
		sums_above[x]     = HSUM_W'(h);
		return 1'b1;
	endfunction

	// Advance the model by one accepted beat and queue the pixel it yields.
	function automatic void predict_blur(logic req, logic [SAMPLE_W-1:0] smp,
			logic invalid);
		int unsigned w, hgt, c, r, x;
		int          s, hs, v, lft, unused;
		bit          hit, last;
		pixel_t      px;
		w    = eff_width();
		hgt  = eff_height();
		hit  = 1'b0;
		last = 1'b0;
		v    = 0;
		if (req == REQ_SAMPLE) begin
			s = invalid ? 0 : int'($signed(smp));
			// Samples are dropped while the previous frame still drains.
			if (drain_owed != 0)
				return;
			live_beats++;
			c = (col_pos >= w) ? 0 : col_pos;
			r = (row_pos >= hgt) ? 0 : row_pos;
			if (c >= 1) begin
				x   = c - 1;
				lft = (x == 0) ? int'(last_smp) : int'(prev_smp);
				hs  = lft + 2 * int'(last_smp) + s;
				hit = shift_column(x, r, hs, v);
			end else if (r >= 1) begin
				// First sample of a row closes the right column of the row above.
				hit = shift_column(w - 1, r - 1, tail_hsum(w), v);
			end
			prev_smp = (c == 0) ? SAMPLE_W'(s) : last_smp;
			last_smp = SAMPLE_W'(s);
			c++;
			if (c >= w) begin
				c = 0;
				r++;
				if (r >= hgt) begin
					r = 0;
					if (hgt == 1) begin
						void'(shift_column(w - 1, 0, tail_hsum(w), unused));
						drain_owed = w;
					end else begin
						drain_owed = w + 1;
					end
				end
			end
			col_pos = c;
			row_pos = r;
		end else begin
			if (drain_owed == 0)
				return;
			live_beats++;
			if (drain_owed > w) begin
				hit = shift_column(w - 1, 1, tail_hsum(w), v);
			end else begin
				// Bottom row: the row below clamps to the bottom row itself.
				x   = w - drain_owed;
				v   = int'(sums_two_above[x]) + 3 * int'(sums_above[x]);
				hit = 1'b1;
			end
			drain_owed--;
			last = (drain_owed == 0);
		end
		if (hit) begin
			px.blurred = v[BLUR_W-1:0];
			px.last    = last;
			owed_pixels.push_back(px);
		end
	endfunction

	// ------------------------------------------------------------------------
	// Receiver: random ready with an optional long hold-off
	// ------------------------------------------------------------------------
	always @(posedge clk) begin
		if (rx_hold_req) begin
			rx_hold_req  = 1'b0;
			rx_hold_left = HOLD_LONG;
		end
		if (rx_hold_left != 0) begin
			rx_hold_left = rx_hold_left - 1;
			m_tready <= 1'b0;
		end else begin
			m_tready <= !(rx_gaps && $urandom_range(99) < 29);
		end
	end

	// Compare each accepted pixel beat with the oldest owed pixel.
	always @(posedge clk) begin : check_pixels
		pixel_t want;
		if (arst_n && m_tvalid && m_tready) begin
			if (owed_pixels.size() == 0) begin
				$error("unexpected pixel: blurred %0d last %0b",
					$signed(m_tdata[BLUR_W-1:0]), m_tlast);
				fails++;
			end else begin
				want = owed_pixels.pop_front();
				if (m_tdata[BLUR_W-1:0] !== want.blurred) begin
					$error("blurred: expected %0d, actual %0d",
						want.blurred, $signed(m_tdata[BLUR_W-1:0]));
					fails++;
				end
				if (m_tlast !== want.last) begin
					$error("last_of_frame: expected %0b, actual %0b",
						want.last, m_tlast);
					fails++;
				end
			end
		end
	end

	// ------------------------------------------------------------------------
	// Shared stimulus tasks
	// ------------------------------------------------------------------------

	// Offer one beat, idling first at random; return at the accepting edge.
	task automatic send_beat(logic req, logic [SAMPLE_W-1:0] smp, logic invalid);
		if (tx_gaps) begin
			while ($urandom_range(99) < 29) begin
				s_tvalid <= 1'b0;
				@(posedge clk);
			end
		end
		s_tvalid <= 1'b1;
		s_tdata  <= smp;
		s_tuser  <= {invalid, req};
		@(posedge clk);
		while (!s_tready)
			@(posedge clk);
		predict_blur(req, smp, invalid);
	endtask

	task automatic send_drain();
		send_beat(REQ_DRAIN, SAMPLE_W'($urandom), 1'($urandom_range(1)));
	endtask

	function automatic logic [SAMPLE_W-1:0] pick_sample();
		case ($urandom_range(7))
			0: return 16'h7FFF;
			1: return 16'h8000;
			2: return 16'h0000;
			default: return SAMPLE_W'($urandom);
		endcase
	endfunction

	// Hold the sender until every owed pixel has arrived.
	task automatic wait_pixels_done();
		s_tvalid <= 1'b0;
		while (owed_pixels.size() != 0)
			@(posedge clk);
	endtask

	// Pixel-free beats may still be in flight once the scoreboard is empty.
	task automatic wait_idle();
		wait_pixels_done();
		repeat (SETTLE) @(posedge clk);
	endtask

	// A register write restarts the frame in the block and in the model.
	task automatic write_reg(logic [CFG_IDX_W-1:0] idx, logic [CFG_DATA_W-1:0] val);
		cfg_we    <= 1'b1;
		cfg_index <= idx;
		cfg_data  <= val;
		@(posedge clk);
		if (idx == CFG_IDX_FRAME_WIDTH)
			width_reg = val[FRAME_W_BITS-1:0];
		else
			height_reg = val[FRAME_H_BITS-1:0];
		col_pos    = 0;
		row_pos    = 0;
		drain_owed = 0;
		cfg_we <= 1'b0;
		@(posedge clk);
	endtask

	task automatic set_frame(int unsigned w, int unsigned h);
		wait_idle();
		if ($urandom_range(1)) begin
			write_reg(CFG_IDX_FRAME_WIDTH, CFG_DATA_W'(w));
			write_reg(CFG_IDX_FRAME_HEIGHT, CFG_DATA_W'(h));
		end else begin
			write_reg(CFG_IDX_FRAME_HEIGHT, CFG_DATA_W'(h));
			write_reg(CFG_IDX_FRAME_WIDTH, CFG_DATA_W'(w));
		end
	endtask

	// ------------------------------------------------------------------------
	// Tests
	// ------------------------------------------------------------------------

	// Reset sizes are 1024 x 1: a few samples give no pixel, and a drain in
	// mid frame has nothing to emit.
	task automatic test_reset_defaults();
		send_beat(REQ_SAMPLE, 16'h7FFF, 1'b0);
		send_beat(REQ_SAMPLE, 16'h8000, 1'b0);
		send_beat(REQ_SAMPLE, 16'hFFFF, 1'b1);
		send_drain();
	endtask

	// 3x3 frame of full-scale values with flagged samples, a sample dropped
	// during the drain, and one drain too many.
	task automatic test_extremes();
		int unsigned i;
		logic [SAMPLE_W-1:0] v;
		set_frame(3, 3);
		for (i = 0; i < 9; i++) begin
			v = (i % 2 == 1) ? 16'h8000 : 16'h7FFF;
			if (i == 4)
				v = 16'h0001;
			send_beat(REQ_SAMPLE, v, (i == 2 || i == 7));
		end
		send_beat(REQ_SAMPLE, 16'h1234, 1'b0);
		repeat (5) send_drain();
	endtask

	// Zero sizes act as a 1x1 frame.
	task automatic test_size_floor();
		set_frame(0, 0);
		send_beat(REQ_SAMPLE, 16'h8000, 1'b0);
		send_drain();
		send_drain();
	endtask

	// Single row: every pixel comes from a drain beat.
	task automatic test_single_row();
		set_frame(2, 1);
		send_beat(REQ_SAMPLE, 16'h7FFF, 1'b0);
		send_beat(REQ_SAMPLE, 16'h8001, 1'b0);
		send_drain();
		send_drain();
	endtask

	// Hold the receiver off long enough that the block backs up into its
	// input, then pause the sender until the scoreboard is empty.
	task automatic test_backpressure();
		int unsigned i;
		set_frame(16, 4);
		rx_hold_req = 1'b1;
		for (i = 0; i < 64; i++)
			send_beat(REQ_SAMPLE, pick_sample(), $urandom_range(99) < 10);
		wait_pixels_done();
		for (i = 0; i < 17; i++)
			send_drain();
		wait_pixels_done();
	endtask

	// Random frames, mostly well formed, with stray drains, dropped samples
	// and frames cut short by a register write.
	task automatic test_random_frames();
		int unsigned goal, frame_no, w, h, n, cut, extra, k, p;
		bit          need_size;
		goal      = live_beats + 200;
		frame_no  = 0;
		need_size = 1'b1;
		while (live_beats < goal) begin
			frame_no++;
			// Run a stretch of frames with no idling on either side.
			tx_gaps = !(frame_no >= 3 && frame_no < 9);
			rx_gaps = tx_gaps;
			if (need_size || $urandom_range(99) < 60) begin
				p = $urandom_range(99);
				if (p < 5)
					w = 0;
				else if (p < 75)
					w = $urandom_range(1, 8);
				else if (p < 95)
					w = $urandom_range(9, 40);
				else
					w = $urandom_range(41, 200);
				p = $urandom_range(99);
				if (p < 5)
					h = 0;
				else if (p < 85 || w > 40)
					h = $urandom_range(1, 4);
				else
					h = $urandom_range(5, 8);
				set_frame(w, h);
			end
			w     = eff_width();
			h     = eff_height();
			n     = w * h;
			extra = $urandom_range(2);
			need_size = ($urandom_range(99) < 8);
			cut   = need_size ? $urandom_range(1, n + w) : n + w + 4;
			for (k = 0; k < n && k < cut; k++) begin
				if ($urandom_range(99) < 4)
					send_drain();
				send_beat(REQ_SAMPLE, pick_sample(), $urandom_range(99) < 10);
			end
			for (k = n; k < n + w + 1 + extra && k < cut; k++) begin
				if ($urandom_range(99) < 8)
					send_beat(REQ_SAMPLE, pick_sample(), 1'($urandom_range(1)));
				send_drain();
			end
		end
		tx_gaps = 1'b1;
		rx_gaps = 1'b1;
	endtask

	// Width above the line-buffer size clamps to it; a few drains show the
	// row length, and the next register write cuts the drain short.
	task automatic test_width_clamp();
		int unsigned i;
		set_frame(2047, 1);
		for (i = 0; i < LINE_MAX; i++)
			send_beat(REQ_SAMPLE, pick_sample(), $urandom_range(99) < 10);
		repeat (4) send_drain();
	endtask

	// An oversize height clamps to the row limit; the frame is cut short after four rows.
	task automatic test_height_clamp();
		int unsigned i;
		set_frame(3, 8191);
		for (i = 0; i < 12; i++)
			send_beat(REQ_SAMPLE, pick_sample(), $urandom_range(99) < 10);
	endtask

	initial begin
		repeat (11) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);
		test_reset_defaults();
		test_extremes();
		test_size_floor();
		test_single_row();
		test_backpressure();
		test_random_frames();
		test_width_clamp();
		test_height_clamp();
		wait_pixels_done();
		repeat (20) @(posedge clk);
		if (fails == 0)
			$display("status: pass");
		else
			$display("status: fail");
		$finish;
	end

	// Run limit, far beyond the slowest correct run.
	initial begin
		#4000000;
		$display("status: fail");
		$finish;
	end

endmodule
